// ----- hw/rtl/trfp_pkg.sv -----
// Shared constants and helpers for the tag reply frame parser.
package trfp_pkg;

    localparam int unsigned LABEL_BYTES = 12;
    localparam int unsigned HDR_LEN     = 4;
    localparam int unsigned LABEL_START = 5;
    localparam int unsigned CHECK_POS   = 17;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned IDX_W       = $clog2(LABEL_BYTES);

    localparam logic [7:0] HDR_B0 = 8'he0;
    localparam logic [7:0] HDR_B1 = 8'h10;
    localparam logic [7:0] HDR_B2 = 8'h82;
    localparam logic [7:0] HDR_B3 = 8'h00;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [7:0]       t_byte;

    function automatic t_byte hdr_byte(input logic [1:0] sel);
        t_byte b;
        unique case (sel)
            2'd0:    b = HDR_B0;
            2'd1:    b = HDR_B1;
            2'd2:    b = HDR_B2;
            default: b = HDR_B3;
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/tag_reply_frame_parser_core.sv -----
// Channel   Dir  Handshake           Payload
// rx        in   i_valid / o_stall   i_rx_byte
// frame     out  o_valid / i_stall   o_frame_status, o_label_upper, o_label_lower
//
// One received word per cycle is sustained while o_stall is low; a word is held in the
// input register, and the check word's frame result is then registered in the output register.
// Only the check word waits for the output register; other words keep moving
// while a finished frame is held by i_stall.
// Synchronous active-low reset clears control state and returns to header hunt.
module tag_reply_frame_parser_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  trfp_pkg::t_byte      i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_frame_status,
    output logic [31:0]          o_label_upper,
    output logic [63:0]          o_label_lower
);
    import trfp_pkg::*;

    logic                r_in_valid;
    t_byte               r_in_byte;
    t_pos                r_pos, n_pos;
    t_byte               r_sum, n_sum;
    t_byte               r_label [LABEL_BYTES];
    logic                r_out_valid;
    logic                r_status;
    logic [31:0]         r_upper;
    logic [63:0]         r_lower;

    t_pos                pos_eff;
    logic                is_hunt;
    logic                is_check;
    logic                is_label;
    logic                out_free;
    logic                consume;
    logic                accept;
    logic [IDX_W-1:0]    label_idx;
    t_byte               sum_add;
    t_byte               expect_chk;
    t_pos                pos_diff;

    assign pos_eff  = (r_pos > t_pos'(CHECK_POS)) ? '0 : r_pos;
    assign is_hunt  = pos_eff < t_pos'(HDR_LEN);
    assign is_check = pos_eff == t_pos'(CHECK_POS);
    assign is_label = (pos_eff >= t_pos'(LABEL_START)) && !is_check;
    assign out_free = !r_out_valid || !i_stall;
    assign consume  = r_in_valid && (!is_check || out_free);
    assign o_stall  = r_in_valid && !consume;
    assign accept   = i_valid && !o_stall;
    assign pos_diff = pos_eff - t_pos'(LABEL_START);
    assign label_idx = pos_diff[IDX_W-1:0];
    assign sum_add  = r_sum + r_in_byte;
    assign expect_chk = 8'd0 - r_sum;

    always_comb begin
        n_pos = pos_eff;
        n_sum = r_sum;
        if (is_hunt) begin
            if (r_in_byte == hdr_byte(pos_eff[1:0])) begin
                n_sum = (pos_eff == '0) ? r_in_byte : sum_add;
                n_pos = pos_eff + t_pos'(1);
            end else if (r_in_byte == HDR_B0) begin
                // restart match on a fresh header start
                n_sum = r_in_byte;
                n_pos = t_pos'(1);
            end else begin
                n_sum = '0;
                n_pos = '0;
            end
        end else if (!is_check) begin
            n_sum = sum_add;
            n_pos = pos_eff + t_pos'(1);
        end else begin
            n_sum = '0;
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
        end else if (consume) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && is_label) begin
            r_label[label_idx] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && is_check) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && is_check) begin
            r_status <= (r_in_byte == expect_chk) ? STATUS_OK : STATUS_BAD;
            r_upper  <= {r_label[0], r_label[1], r_label[2], r_label[3]};
            r_lower  <= {r_label[4], r_label[5], r_label[6], r_label[7],
                         r_label[8], r_label[9], r_label[10], r_label[11]};
        end
    end

    assign o_valid        = r_out_valid;
    assign o_frame_status = r_status;
    assign o_label_upper  = r_upper;
    assign o_label_lower  = r_lower;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= t_pos'(CHECK_POS))
        else $error("frame position out of range");

    a_check_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && is_check |=> r_out_valid && r_pos == '0)
        else $error("check word did not produce a frame");

    a_sum_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos == '0 |-> r_sum == '0)
        else $error("running sum not cleared while hunting");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid)
        else $error("held frame dropped");

endmodule

// ----- test/tb_tag_reply_frame_parser_core.sv -----
// Self-checking testbench for the tag reply frame parser core.
`timescale 1ns / 100ps

module tb_tag_reply_frame_parser_core;
    import trfp_pkg::*;

    typedef struct {
        logic        status;
        logic [31:0] upper;
        logic [63:0] lower;
    } t_frame;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_byte       i_rx_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_frame_status;
    logic [31:0] o_label_upper;
    logic [63:0] o_label_lower;

    tag_reply_frame_parser_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_status (o_frame_status),
        .o_label_upper  (o_label_upper),
        .o_label_lower  (o_label_lower)
    );

    t_byte  rx_bytes_q[$];
    t_frame frame_q[$];
    int     mismatches = 0;
    int     bytes_taken = 0;
    bit     steady = 1'b0;
    int     hold_left = 0;
    bit     hold_done = 1'b0;

    // parser state mirror
    t_pos   hunt_pos = '0;
    t_byte  run_sum = '0;
    t_byte  label_mem [LABEL_BYTES];
    t_byte  hdr_seq [HDR_LEN] = '{HDR_B0, HDR_B1, HDR_B2, HDR_B3};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s at %0t: got %h want %h", what, $realtime, got, want);
        mismatches++;
    endtask

    task automatic parse_rx_byte(input t_byte b);
        t_pos   p;
        t_byte  neg;
        t_frame f;
        p = hunt_pos;
        if (p > CHECK_POS) p = '0;
        if (p < HDR_LEN) begin
            if (b == hdr_seq[p]) begin
                run_sum = (p == 0) ? b : t_byte'(run_sum + b);
                hunt_pos = p + 1'b1;
            end else if (b == HDR_B0) begin
                // restart the header match on this word
                run_sum = b;
                hunt_pos = t_pos'(1);
            end else begin
                run_sum = '0;
                hunt_pos = '0;
            end
        end else if (p < CHECK_POS) begin
            run_sum = t_byte'(run_sum + b);
            if (p >= LABEL_START) label_mem[p - LABEL_START] = b;
            hunt_pos = p + 1'b1;
        end else begin
            neg = 8'd0 - run_sum;
            f.status = (b == neg) ? STATUS_OK : STATUS_BAD;
            f.upper = {label_mem[0], label_mem[1], label_mem[2], label_mem[3]};
            f.lower = {label_mem[4], label_mem[5], label_mem[6], label_mem[7],
                       label_mem[8], label_mem[9], label_mem[10], label_mem[11]};
            frame_q.push_back(f);
            hunt_pos = '0;
            run_sum = '0;
        end
    endtask

    // Build one frame; corrupt the check word unless good_check is set.
    task automatic add_frame(input bit good_check);
        t_byte body [CHECK_POS];
        t_byte sum;
        sum = '0;
        for (int k = 0; k < CHECK_POS; k++) begin
            body[k] = (k < HDR_LEN) ? hdr_seq[k] : t_byte'($urandom);
            sum = t_byte'(sum + body[k]);
            rx_bytes_q.push_back(body[k]);
        end
        sum = 8'd0 - sum;
        if (!good_check) sum = sum ^ t_byte'($urandom_range(1, 255));
        rx_bytes_q.push_back(sum);
    endtask

    function automatic t_byte noise_byte();
        case ($urandom_range(0, 5))
            0: return HDR_B0;
            1: return HDR_B1;
            2: return HDR_B2;
            3: return HDR_B3;
            default: return t_byte'($urandom);
        endcase
    endfunction

    task automatic add_random(input int n_bytes);
        int stop_at;
        int sel;
        int cut;
        stop_at = rx_bytes_q.size() + n_bytes;
        while (rx_bytes_q.size() < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                add_frame($urandom_range(0, 3) != 0);
            end else if (sel < 85) begin
                // partial header, then a stray word
                cut = $urandom_range(1, HDR_LEN - 1);
                for (int k = 0; k < cut; k++) rx_bytes_q.push_back(hdr_seq[k]);
                rx_bytes_q.push_back(noise_byte());
            end else begin
                repeat ($urandom_range(1, 6)) rx_bytes_q.push_back(noise_byte());
            end
        end
    endtask

    task automatic wait_drained();
        while (rx_bytes_q.size() != 0 || i_valid || frame_q.size() != 0) @(negedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_rx_byte(i_rx_byte);
                bytes_taken <= bytes_taken + 1;
            end
            // hold the word while stalled
            if (!i_valid || !o_stall) begin
                if (rx_bytes_q.size() != 0 && (steady || $urandom_range(0, 99) >= 24)) begin
                    i_valid <= 1'b1;
                    i_rx_byte <= rx_bytes_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                    i_rx_byte <= t_byte'($urandom);
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_taken >= 800) begin
            // long hold-off: let the parser back up into its input
            i_stall <= 1'b1;
            hold_left <= 400;
            hold_done <= 1'b1;
        end else begin
            i_stall <= !steady && ($urandom_range(0, 99) < 24);
        end
    end

    // frame checker
    always @(posedge i_clk) begin
        t_frame f;
        if (i_rst_n && o_valid && !i_stall) begin
            if (frame_q.size() == 0) begin
                report("unexpected frame", {63'd0, o_frame_status}, 64'd0);
            end else begin
                f = frame_q.pop_front();
                if (o_frame_status !== f.status)
                    report("frame_status", {63'd0, o_frame_status}, {63'd0, f.status});
                if (o_label_upper !== f.upper)
                    report("label_upper", {32'd0, o_label_upper}, {32'd0, f.upper});
                if (o_label_lower !== f.lower)
                    report("label_lower", o_label_lower, f.lower);
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // stray word, doubled header start, all-ones/all-zeros body, bad check word
        rx_bytes_q.push_back(8'h55);
        rx_bytes_q.push_back(HDR_B0);
        for (int k = 0; k < HDR_LEN; k++) rx_bytes_q.push_back(hdr_seq[k]);
        for (int k = HDR_LEN; k < CHECK_POS; k++)
            rx_bytes_q.push_back(k[0] ? 8'hff : 8'h00);
        rx_bytes_q.push_back(8'h5a);
        // header broken by a zero word at the wrong place
        rx_bytes_q.push_back(HDR_B0);
        rx_bytes_q.push_back(HDR_B1);
        rx_bytes_q.push_back(HDR_B3);

        add_random(550);
        wait_drained();

        steady = 1'b1;
        add_random(450);
        while (rx_bytes_q.size() != 0) @(negedge i_clk);
        steady = 1'b0;

        add_random(620);
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
